[design/nms4_pkg.sv]
// ----------------------------------------------------------------------------
// nms4_pkg
// Shared types and constants for the four-neighbour non-maximum suppressor.
// ----------------------------------------------------------------------------
package nms4_pkg;

    // default parameter values
    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;
    localparam int DEF_VALUE_BITS = 32;

    // configuration port
    localparam int CFG_INDEX_W    = 1;
    localparam int CFG_DATA_W     = 11;
    localparam int CFG_RESET_SIZE = 1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } t_cfg_reg;

    // result position fields
    localparam int POS_W = 10;

    // queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } t_q_status;

endpackage

[design/nms4_ram.sv]
// ----------------------------------------------------------------------------
// nms4_ram
// Generic memory: one write port, two registered read ports, read-first.
// ----------------------------------------------------------------------------
module nms4_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]         o_rdata_a,
    output logic [WIDTH-1:0]         o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata_a <= r_mem[i_raddr_a];
            r_rdata_b <= r_mem[i_raddr_b];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

[design/nms4_queue.sv]
// ----------------------------------------------------------------------------
// nms4_queue
// Short register queue carrying classified pixel records to the back end.
// ----------------------------------------------------------------------------
module nms4_queue
    import nms4_pkg::*;
#(
    parameter int WIDTH = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_head_data,
    output t_q_status        o_status
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    logic [WIDTH-1:0]  r_data [QUEUE_DEPTH];
    logic [PW-1:0]     r_wptr;
    logic [PW-1:0]     r_rptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + QCNT_W'(1);
            2'b01:   n_count = r_count - QCNT_W'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + PW'(1);
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wptr] <= i_push_data;
        end
    end

    assign o_head_data    = r_data[r_rptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.count = r_count;

endmodule

[design/nms4_front.sv]
// ----------------------------------------------------------------------------
// nms4_front
// Accepts pixels, tracks raster position, reads and updates both line
// stores and decides each verdict in the cycle after the pixel is accepted.
// ----------------------------------------------------------------------------
module nms4_front
    import nms4_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int ENTRY_W    = 2 * VALUE_BITS + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 2
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic signed [VALUE_BITS-1:0]       i_pixel_value,
    input  logic [$clog2(MAX_WIDTH + 1)-1:0]   i_width,
    input  logic [$clog2(MAX_HEIGHT + 1)-1:0]  i_height,
    output logic                               o_push,
    output logic [ENTRY_W-1:0]                 o_push_data,
    input  t_q_status                          i_q_status
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int RW  = $clog2(MAX_HEIGHT);
    localparam int WSW = $clog2(MAX_WIDTH + 1);
    localparam int HSW = $clog2(MAX_HEIGHT + 1);

    // raster counters
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;

    // position of the arriving pixel
    logic [CW-1:0] c_cl;
    logic [RW-1:0] r_cl;
    logic [CW-1:0] c_left;
    logic [CW-1:0] c_right;
    logic          col_last;
    logic          row_last;
    logic          accept;

    // verdict stage
    logic                         r_b_valid;
    logic signed [VALUE_BITS-1:0] r_b_px;
    logic [CW-1:0]                r_b_col;
    logic [RW-1:0]                r_b_row;
    logic                         r_b_interior;
    logic                         r_b_has_verdict;
    logic                         r_b_last_row;
    logic                         r_up_byp;
    logic                         r_left_byp;
    logic signed [VALUE_BITS-1:0] r_byp_data;

    logic signed [VALUE_BITS-1:0] prev_rd_a;
    logic signed [VALUE_BITS-1:0] prev_rd_b;
    logic signed [VALUE_BITS-1:0] older_rd_a;
    logic signed [VALUE_BITS-1:0] older_rd_b;
    logic signed [VALUE_BITS-1:0] centre;
    logic signed [VALUE_BITS-1:0] up;
    logic signed [VALUE_BITS-1:0] left;
    logic signed [VALUE_BITS-1:0] right;
    logic signed [VALUE_BITS-1:0] verdict;
    logic                         suppress;

    always_comb begin
        if (WSW'(r_col) >= i_width) begin
            c_cl = CW'(i_width - WSW'(1));
        end else begin
            c_cl = r_col;
        end
        if (HSW'(r_row) >= i_height) begin
            r_cl = RW'(i_height - HSW'(1));
        end else begin
            r_cl = r_row;
        end
        col_last = (WSW'(c_cl) + WSW'(1)) >= i_width;
        row_last = (HSW'(r_cl) + HSW'(1)) >= i_height;
        c_left   = (c_cl == '0) ? '0 : c_cl - CW'(1);
        c_right  = col_last ? c_cl : c_cl + CW'(1);
    end

    assign o_ready = (32'(i_q_status.count) + 32'(r_b_valid)) < QUEUE_DEPTH;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_b_valid <= 1'b0;
        end else begin
            r_b_valid <= accept;
            if (accept) begin
                if (col_last) begin
                    r_col <= '0;
                    r_row <= row_last ? '0 : r_cl + RW'(1);
                end else begin
                    r_col <= c_cl + CW'(1);
                    r_row <= r_cl;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_px          <= i_pixel_value;
            r_b_col         <= c_cl;
            r_b_row         <= r_cl;
            r_b_interior    <= (r_cl >= RW'(2)) && (c_cl != '0) && !col_last;
            r_b_has_verdict <= (r_cl != '0);
            r_b_last_row    <= row_last;
            r_up_byp        <= r_b_valid && (r_b_col == c_cl);
            r_left_byp      <= r_b_valid && (r_b_col == c_left);
            r_byp_data      <= prev_rd_a;
        end
    end

    // previous line: rows r-1 / r
    nms4_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_prev_line (
        .i_clk     (i_clk),
        .i_we      (accept),
        .i_waddr   (c_cl),
        .i_wdata   (i_pixel_value),
        .i_re      (accept),
        .i_raddr_a (c_cl),
        .i_raddr_b (c_right),
        .o_rdata_a (prev_rd_a),
        .o_rdata_b (prev_rd_b)
    );

    // older line: rows r-2 / r-1, written in the cycle after the pixel arrives, with the centre
    nms4_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_older_line (
        .i_clk     (i_clk),
        .i_we      (r_b_valid),
        .i_waddr   (r_b_col),
        .i_wdata   (prev_rd_a),
        .i_re      (accept),
        .i_raddr_a (c_cl),
        .i_raddr_b (c_left),
        .o_rdata_a (older_rd_a),
        .o_rdata_b (older_rd_b)
    );

    always_comb begin
        centre   = prev_rd_a;
        right    = prev_rd_b;
        up       = r_up_byp ? r_byp_data : older_rd_a;
        left     = r_left_byp ? r_byp_data : older_rd_b;
        suppress = r_b_interior &&
                   ((up >= centre) || (left >= centre) ||
                    (right >= centre) || (r_b_px >= centre));
        verdict  = suppress ? '0 : centre;
    end

    assign o_push      = r_b_valid && (r_b_has_verdict || r_b_last_row);
    assign o_push_data = {r_b_px, verdict, r_b_row, r_b_col, r_b_has_verdict, r_b_last_row};

endmodule

[design/nms4_back.sv]
// ----------------------------------------------------------------------------
// nms4_back
// Expands queued pixel records into one or two results and drives the
// registered output channel.
// ----------------------------------------------------------------------------
module nms4_back
    import nms4_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int VALUE_BITS = DEF_VALUE_BITS,
    parameter int ENTRY_W    = 2 * VALUE_BITS + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 2
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ENTRY_W-1:0]           i_head_data,
    input  t_q_status                    i_q_status,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [POS_W-1:0]             o_out_row,
    output logic [POS_W-1:0]             o_out_column,
    output logic signed [VALUE_BITS-1:0] o_out_value,
    output logic                         o_last_of_run
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);

    logic signed [VALUE_BITS-1:0] h_px;
    logic signed [VALUE_BITS-1:0] h_verdict;
    logic [RW-1:0]                h_row;
    logic [CW-1:0]                h_col;
    logic                         h_has_verdict;
    logic                         h_last_row;

    logic                         r_phase;
    logic                         r_out_valid;
    logic [POS_W-1:0]             r_out_row;
    logic [POS_W-1:0]             r_out_col;
    logic signed [VALUE_BITS-1:0] r_out_value;
    logic                         r_out_last;

    logic                         load;
    logic                         emit_verdict;
    logic                         final_result;

    assign {h_px, h_verdict, h_row, h_col, h_has_verdict, h_last_row} = i_head_data;

    assign load         = !i_q_status.empty && (!r_out_valid || i_ready);
    assign emit_verdict = h_has_verdict && !r_phase;
    assign final_result = !(emit_verdict && h_last_row);
    assign o_pop        = load && final_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
                r_phase     <= !final_result;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_col <= POS_W'(h_col);
            if (emit_verdict) begin
                r_out_row   <= POS_W'(h_row - RW'(1));
                r_out_value <= h_verdict;
                r_out_last  <= !h_last_row;
            end else begin
                r_out_row   <= POS_W'(h_row);
                r_out_value <= h_px;
                r_out_last  <= 1'b1;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_row     = r_out_row;
    assign o_out_column  = r_out_col;
    assign o_out_value   = r_out_value;
    assign o_last_of_run = r_out_last;

endmodule

[design/four_neighbour_nonmax_suppress_top.sv]
// ----------------------------------------------------------------------------
// four_neighbour_nonmax_suppress_top
// Four-neighbour non-maximum suppression over a raster pixel stream.
// ----------------------------------------------------------------------------
// Pixels enter one per clock in raster order while o_ready is high. Each pixel
// releases the verdict for the pixel directly above it (zero if any of its four
// neighbours is greater or equal, border pixels unchanged); pixels of the last
// row are also emitted themselves, so the last row delivers two results per
// pixel (one in a single-row frame) through the single output register. All
// other rows sustain one pixel per cycle while the output is not stalled. Two
// line stores of MAX_WIDTH entries are read at two addresses per pixel; they
// need no clearing after reset. Size registers are clamped to 1..MAX and are
// meant to change between frames.
module four_neighbour_nonmax_suppress_top
    import nms4_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]       i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [VALUE_BITS-1:0] i_pixel_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [POS_W-1:0]             o_out_row,
    output logic [POS_W-1:0]             o_out_column,
    output logic signed [VALUE_BITS-1:0] o_out_value,
    output logic                         o_last_of_run
);

    localparam int WSW     = $clog2(MAX_WIDTH + 1);
    localparam int HSW     = $clog2(MAX_HEIGHT + 1);
    localparam int ENTRY_W = 2 * VALUE_BITS + $clog2(MAX_WIDTH) + $clog2(MAX_HEIGHT) + 2;
    localparam int RST_W   = (CFG_RESET_SIZE > MAX_WIDTH) ? MAX_WIDTH : CFG_RESET_SIZE;
    localparam int RST_H   = (CFG_RESET_SIZE > MAX_HEIGHT) ? MAX_HEIGHT : CFG_RESET_SIZE;

    logic [WSW-1:0]     r_width;
    logic [WSW-1:0]     n_width;
    logic [HSW-1:0]     r_height;
    logic [HSW-1:0]     n_height;

    logic               push;
    logic [ENTRY_W-1:0] push_data;
    logic               pop;
    logic [ENTRY_W-1:0] head_data;
    t_q_status          q_status;

    // clamp written sizes to 1..MAX
    always_comb begin
        if (i_cfg_data == '0) begin
            n_width  = WSW'(1);
            n_height = HSW'(1);
        end else begin
            if (32'(i_cfg_data) > 32'(MAX_WIDTH)) begin
                n_width = WSW'(MAX_WIDTH);
            end else begin
                n_width = WSW'(i_cfg_data);
            end
            if (32'(i_cfg_data) > 32'(MAX_HEIGHT)) begin
                n_height = HSW'(MAX_HEIGHT);
            end else begin
                n_height = HSW'(i_cfg_data);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WSW'(RST_W);
            r_height <= HSW'(RST_H);
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_IMAGE_WIDTH:  r_width  <= n_width;
                REG_IMAGE_HEIGHT: r_height <= n_height;
                default: begin
                    r_width <= r_width;
                end
            endcase
        end
    end

    nms4_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .VALUE_BITS (VALUE_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel_value (i_pixel_value),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_push        (push),
        .o_push_data   (push_data),
        .i_q_status    (q_status)
    );

    nms4_queue #(
        .WIDTH (ENTRY_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head_data (head_data),
        .o_status    (q_status)
    );

    nms4_back #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .VALUE_BITS (VALUE_BITS),
        .ENTRY_W    (ENTRY_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head_data   (head_data),
        .i_q_status    (q_status),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_row     (o_out_row),
        .o_out_column  (o_out_column),
        .o_out_value   (o_out_value),
        .o_last_of_run (o_last_of_run)
    );

endmodule

[tb/nms4_checker.sv]
// ----------------------------------------------------------------------------
// nms4_checker
// Watches the pixel request and result channels of the suppressor, predicts
// every result from its own copy of the line stores, counters and size
// registers, and compares each delivered result with the oldest prediction.
// ----------------------------------------------------------------------------
module nms4_checker
    import nms4_pkg::*;
(
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [CFG_INDEX_W-1:0]           i_cfg_index,
    input  logic [CFG_DATA_W-1:0]            i_cfg_data,
    input  logic                             i_req_valid,
    input  logic                             i_req_ready,
    input  logic signed [DEF_VALUE_BITS-1:0] i_pixel_value,
    input  logic                             i_res_valid,
    input  logic                             i_res_ready,
    input  logic [POS_W-1:0]                 i_out_row,
    input  logic [POS_W-1:0]                 i_out_column,
    input  logic signed [DEF_VALUE_BITS-1:0] i_out_value,
    input  logic                             i_out_last,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [DEF_VALUE_BITS-1:0] t_pixel;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] column;
        t_pixel           value;
        logic             last;
    } t_verdict;

    t_pixel                older_row [DEF_MAX_WIDTH];
    t_pixel                upper_row [DEF_MAX_WIDTH];
    int unsigned           row_pos = 0;
    int unsigned           col_pos = 0;
    logic [CFG_DATA_W-1:0] width_reg = CFG_RESET_SIZE;
    logic [CFG_DATA_W-1:0] height_reg = CFG_RESET_SIZE;
    t_verdict              due_verdicts [$];
    int                    fails = 0;
    int                    pending_cnt = 0;

    assign o_fail_count = fails;
    assign o_pending    = pending_cnt;

    function automatic int unsigned clamp_size(input logic [CFG_DATA_W-1:0] v,
                                               input int unsigned top);
        if (v == 0)
            return 1;
        if (v > top)
            return top;
        return v;
    endfunction

    task automatic predict_verdicts(input t_pixel px);
        int unsigned w;
        int unsigned h;
        int unsigned r;
        int unsigned c;
        t_pixel      kept;
        t_verdict    due;
        w = clamp_size(width_reg, DEF_MAX_WIDTH);
        h = clamp_size(height_reg, DEF_MAX_HEIGHT);
        r = (row_pos >= h) ? h - 1 : row_pos;
        c = (col_pos >= w) ? w - 1 : col_pos;
        // verdict for the pixel above the arriving one
        if (r >= 1) begin
            kept = upper_row[c];
            if (r >= 2 && c >= 1 && c + 1 < w &&
                (older_row[c] >= kept || older_row[c-1] >= kept ||
                 upper_row[c+1] >= kept || px >= kept))
                kept = '0;
            due = '{row: POS_W'(r - 1), column: POS_W'(c),
                    value: kept, last: (r + 1 < h)};
            due_verdicts = {due_verdicts, due};
        end
        // last row passes straight through as well
        if (r + 1 >= h) begin
            due = '{row: POS_W'(r), column: POS_W'(c),
                    value: px, last: 1'b1};
            due_verdicts = {due_verdicts, due};
        end
        older_row[c] = upper_row[c];
        upper_row[c] = px;
        if (c + 1 >= w) begin
            col_pos = 0;
            row_pos = (r + 1 >= h) ? 0 : r + 1;
        end else begin
            col_pos = c + 1;
            row_pos = r;
        end
    endtask

    always @(posedge i_clk) begin : watch_channels
        t_verdict got;
        t_verdict want;
        if (!i_rst_n) begin
            due_verdicts.delete();
            row_pos    = 0;
            col_pos    = 0;
            width_reg  = CFG_RESET_SIZE;
            height_reg = CFG_RESET_SIZE;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_IMAGE_WIDTH)
                    width_reg = i_cfg_data;
                else if (i_cfg_index == REG_IMAGE_HEIGHT)
                    height_reg = i_cfg_data;
            end
            if (i_res_valid && i_res_ready) begin
                got = '{row: i_out_row, column: i_out_column,
                        value: i_out_value, last: i_out_last};
                if (due_verdicts.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result, expected none, got row %0d column %0d",
                             $time, got.row, got.column,
                             " value %0d last %0d", got.value, got.last);
                end else begin
                    want = due_verdicts.pop_front();
                    if (got.row !== want.row || got.column !== want.column ||
                        got.value !== want.value || got.last !== want.last) begin
                        fails++;
                        $display("%0t: result mismatch, expected row %0d column %0d",
                                 $time, want.row, want.column,
                                 " value %0d last %0d, got row %0d column %0d",
                                 want.value, want.last, got.row, got.column,
                                 " value %0d last %0d", got.value, got.last);
                    end
                end
            end
            if (i_req_valid && i_req_ready)
                predict_verdicts(i_pixel_value);
        end
        pending_cnt <= due_verdicts.size();
    end

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Drives frames of pixels into the four-neighbour suppressor: a few small
// hand-made frames, one tallest frame, then frames of random size and
// content, with random gaps on both channels. Size registers change only
// between frames once all results are in. The checker beside the block
// predicts and compares; this module reports the verdict.
// ----------------------------------------------------------------------------
module tb_top
    import nms4_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    typedef logic signed [DEF_VALUE_BITS-1:0] t_pixel;

    localparam int     TOTAL_ITEMS    = 1450;
    localparam int     RANDOM_ITEMS   = TOTAL_ITEMS - DEF_MAX_HEIGHT;
    localparam int     WATCHDOG_LIMIT = 4000;
    localparam int     DRAIN_CYCLES   = 8;
    localparam t_pixel PIX_MIN        = 32'sh8000_0000;
    localparam t_pixel PIX_MAX        = 32'sh7fff_ffff;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] i_cfg_index = REG_IMAGE_WIDTH;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                   i_valid = 1'b0;
    logic                   o_ready;
    t_pixel                 i_pixel_value = '0;
    logic                   o_valid;
    logic                   i_ready = 1'b0;
    logic [POS_W-1:0]       o_out_row;
    logic [POS_W-1:0]       o_out_column;
    t_pixel                 o_out_value;
    logic                   o_last_of_run;

    int          fail_count;
    int          pending;
    int unsigned tx_idle_pct = 14;
    int unsigned rx_idle_pct = 61;
    int unsigned random_sent = 0;
    int unsigned idle_cycles = 0;

    four_neighbour_nonmax_suppress_top DUT (.*);

    nms4_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_req_valid   (i_valid),
        .i_req_ready   (o_ready),
        .i_pixel_value (i_pixel_value),
        .i_res_valid   (o_valid),
        .i_res_ready   (i_ready),
        .i_out_row     (o_out_row),
        .i_out_column  (o_out_column),
        .i_out_value   (o_out_value),
        .i_out_last    (o_last_of_run),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_pixel rand_pixel();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return t_pixel'($urandom_range(0, 6)) - 3;
            4: begin
                case ($urandom_range(0, 3))
                    0: return PIX_MIN;
                    1: return PIX_MAX;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return t_pixel'($urandom);
        endcase
    endfunction

    task automatic send_pixel(input t_pixel px);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_pixel_value <= px;
        do
            @(posedge i_clk);
        while (!o_ready);
    endtask

    // wait for every result, then let the pipeline settle
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic start_frame(input logic [CFG_DATA_W-1:0] w,
                               input logic [CFG_DATA_W-1:0] h);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= REG_IMAGE_WIDTH;
        i_cfg_data  <= w;
        @(posedge i_clk);
        i_cfg_index <= REG_IMAGE_HEIGHT;
        i_cfg_data  <= h;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_frame(input logic [CFG_DATA_W-1:0] w,
                                input logic [CFG_DATA_W-1:0] h,
                                output int unsigned n);
        n = (w == 0 ? 1 : (w > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : w)) *
            (h == 0 ? 1 : (h > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : h));
        start_frame(w, h);
        repeat (n) send_pixel(rand_pixel());
    endtask

    task automatic random_frames(input int unsigned upto);
        int unsigned n;
        logic [CFG_DATA_W-1:0] w;
        logic [CFG_DATA_W-1:0] h;
        while (random_sent < upto) begin
            w = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(10, 48)) :
                                              CFG_DATA_W'($urandom_range(0, 9));
            h = ($urandom_range(0, 9) == 0) ? CFG_DATA_W'($urandom_range(8, 20)) :
                                              CFG_DATA_W'($urandom_range(0, 7));
            random_frame(w, h, n);
            random_sent += n;
        end
    endtask

    initial begin : stimulus
        int unsigned n;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // interior ties on both sides, extreme values on the border
        start_frame(4, 3);
        send_pixel(PIX_MIN); send_pixel(32'sh8000_0001); send_pixel(1); send_pixel(PIX_MAX);
        send_pixel(-5); send_pixel(PIX_MAX); send_pixel(PIX_MAX); send_pixel(7);
        send_pixel(0); send_pixel(1); send_pixel(PIX_MIN); send_pixel(-1);

        // zero sizes: a single pixel that is first and last row at once
        start_frame(0, 0);
        send_pixel(32'sh55aa_33cc);

        // negative local maximum survives
        start_frame(3, 3);
        send_pixel(-9); send_pixel(-8); send_pixel(-7);
        send_pixel(-6); send_pixel(-2); send_pixel(-3);
        send_pixel(-4); send_pixel(-5); send_pixel(-1);

        random_frames(RANDOM_ITEMS / 3);

        tx_idle_pct <= 61;
        rx_idle_pct <= 14;
        random_frame(0, 11'h7ff, n);
        random_frames(2 * RANDOM_ITEMS / 3);

        tx_idle_pct <= 0;
        rx_idle_pct <= 0;
        random_frames(RANDOM_ITEMS);

        drain();
        if (fail_count == 0 && pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
